// ===== rtl/ddq_pkg.sv =====
// ddq_pkg: shared sizes, command and result codes, and the queue item type
// for the bounded deque block; no dependencies
`timescale 1ns / 1ps

package ddq_pkg;

  // store size and derived widths
  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int RUN_MAX     = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  // command codes on in_cmd
  localparam logic [3:0] CMD_ADD_FRONT   = 4'd0;
  localparam logic [3:0] CMD_ADD_BACK    = 4'd1;
  localparam logic [3:0] CMD_REM_FRONT   = 4'd2;
  localparam logic [3:0] CMD_REM_BACK    = 4'd3;
  localparam logic [3:0] CMD_REM_VAL     = 4'd4;
  localparam logic [3:0] CMD_PRINT_ALL   = 4'd5;
  localparam logic [3:0] CMD_PRINT_FIRST = 4'd6;
  localparam logic [3:0] CMD_PRINT_LAST  = 4'd7;
  localparam logic [3:0] CMD_CLEAR       = 4'd8;

  // decoded operation carried through the queue
  typedef enum logic [3:0] {
    OP_ADD_FRONT,
    OP_ADD_BACK,
    OP_REM_FRONT,
    OP_REM_BACK,
    OP_REM_VAL,
    OP_PRINT_ALL,
    OP_PRINT_FIRST,
    OP_PRINT_LAST,
    OP_CLEAR
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ELEM  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_PRINT
  } state_t;

  // one classified command
  typedef struct packed {
    op_t              op;
    logic [31:0]      value;
    logic [CNT_W-1:0] n;
  } q_item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/ddq_front.sv =====
// ddq_front: decodes incoming commands, drops unknown codes and clamps
// the read-out count; depends on ddq_pkg
`timescale 1ns / 1ps

module ddq_front (
  input  logic                  start,
  input  logic                  q_full,
  input  logic [3:0]            in_cmd,
  input  logic signed [31:0]    in_operand,
  output logic                  busy,
  output logic                  push,
  output ddq_pkg::q_item_t      push_item
);
  import ddq_pkg::*;

  logic             known;
  logic [CNT_W-1:0] n_sat;

  // queue full holds off the sender
  assign busy = q_full;

  // negative counts become zero, large counts saturate to the store size
  always_comb begin
    if (in_operand[31]) begin
      n_sat = '0;
    end else if (in_operand[30:0] > 31'(DEPTH)) begin
      n_sat = CNT_W'(DEPTH);
    end else begin
      n_sat = in_operand[CNT_W-1:0];
    end
  end

  // command decode
  always_comb begin
    known        = 1'b1;
    push_item.op = OP_CLEAR;
    case (in_cmd)
      CMD_ADD_FRONT:   push_item.op = OP_ADD_FRONT;
      CMD_ADD_BACK:    push_item.op = OP_ADD_BACK;
      CMD_REM_FRONT:   push_item.op = OP_REM_FRONT;
      CMD_REM_BACK:    push_item.op = OP_REM_BACK;
      CMD_REM_VAL:     push_item.op = OP_REM_VAL;
      CMD_PRINT_ALL:   push_item.op = OP_PRINT_ALL;
      CMD_PRINT_FIRST: push_item.op = OP_PRINT_FIRST;
      CMD_PRINT_LAST:  push_item.op = OP_PRINT_LAST;
      CMD_CLEAR:       push_item.op = OP_CLEAR;
      default:         known = 1'b0;
    endcase
    push_item.value = in_operand;
    push_item.n     = n_sat;
  end

  // unknown commands are taken and dropped
  assign push = start && !q_full && known;

endmodule

// ===== rtl/ddq_queue.sv =====
// ddq_queue: small command queue between front and back end
// depends on ddq_pkg
`timescale 1ns / 1ps

module ddq_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ddq_pkg::q_item_t      push_item,
  input  logic                  pop,
  output logic                  q_full,
  output logic                  q_valid,
  output ddq_pkg::q_item_t      q_item
);
  import ddq_pkg::*;

  q_item_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  assign q_full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/ddq_back.sv =====
// ddq_back: entry memory kept as a ring, executes commands and walks
// the store for remove-by-value and read-outs; depends on ddq_pkg
`timescale 1ns / 1ps

module ddq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  ddq_pkg::q_item_t      q_item,
  output logic                  pop,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic signed [31:0]    out_element,
  output logic                  out_last_of_run
);
  import ddq_pkg::*;

  // entry memory, one write and one registered read per cycle
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;
  logic [PTR_W-1:0] raddr;
  logic [PTR_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             we;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] run_len;
  logic             full;

  // ring address of a position counted from the front
  function automatic logic [PTR_W-1:0] ring_addr(logic [PTR_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign full = (count_r == CNT_W'(DEPTH));

  // read-out length: clamp to stored count, then to the run limit
  always_comb begin
    if (q_item.op == OP_PRINT_ALL) begin
      n_eff = count_r;
    end else begin
      n_eff = (q_item.n > count_r) ? count_r : q_item.n;
    end
    run_len = (n_eff > CNT_W'(RUN_MAX)) ? CNT_W'(RUN_MAX) : n_eff;
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = 1'b0;
    start_nxt     = start_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = 1'b0;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = head_r;
    wdata         = q_item.value;
    raddr         = ring_addr(head_r, i_r);

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_item.op)
            OP_ADD_FRONT: begin
              if (full) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_FULL;
                out_last_nxt  = 1'b1;
              end else begin
                head_nxt  = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - 1'b1;
                we        = 1'b1;
                waddr     = head_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_ADD_BACK: begin
              if (full) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_FULL;
                out_last_nxt  = 1'b1;
              end else begin
                we        = 1'b1;
                waddr     = ring_addr(head_r, count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            OP_REM_FRONT: begin
              if (count_r != '0) begin
                head_nxt  = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_REM_BACK: begin
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_REM_VAL: begin
              if (count_r != '0) begin
                val_nxt   = q_item.value;
                i_nxt     = '0;
                j_nxt     = '0;
                state_nxt = ST_DEL;
              end
            end
            OP_PRINT_ALL, OP_PRINT_FIRST, OP_PRINT_LAST: begin
              if (q_item.op == OP_PRINT_ALL && count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_EMPTY;
                out_last_nxt  = 1'b1;
              end else if (n_eff == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_NONE;
                out_last_nxt  = 1'b1;
              end else begin
                len_nxt   = run_len;
                start_nxt = (q_item.op == OP_PRINT_LAST) ? count_r - run_len : '0;
                k_nxt     = '0;
                state_nxt = ST_PRINT;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // compaction: read position i, keep it at position j if it differs
      ST_DEL: begin
        if (i_r != count_r) begin
          raddr    = ring_addr(head_r, i_r);
          i_nxt    = i_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r && (rd_data_r != val_r)) begin
          we    = 1'b1;
          waddr = ring_addr(head_r, j_r);
          wdata = rd_data_r;
          j_nxt = j_r + 1'b1;
        end
        if (i_r == count_r && !pend_r) begin
          count_nxt = j_r;
          state_nxt = ST_IDLE;
        end
      end

      // read-out: one entry per cycle straight to the output
      ST_PRINT: begin
        raddr         = ring_addr(head_r, start_r + k_r);
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ELEM;
        out_last_nxt  = (k_r == len_r - 1'b1);
        k_nxt         = k_r + 1'b1;
        if (k_r == len_r - 1'b1) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    start_r    <= start_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    val_r      <= val_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  // entry memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // result ports
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_last_of_run = out_last_r;
  assign out_element     = (out_kind_r == KIND_ELEM) ? rd_data_r : '0;

endmodule

// ===== rtl/bounded_deque_with_value_delete.sv =====
// bounded_deque_with_value_delete: top level of the bounded deque
// depends on ddq_pkg, ddq_front, ddq_queue, ddq_back
// Single results are registered by the back end once the command leaves the command
// queue; read-out elements also pass the read-out state and the registered memory read.
// Adds, removes and clear are executed directly from the idle state; a read-out makes one
// memory read per element; remove-by-value on a non-empty store makes one memory read per
// entry and one write per kept entry. A two-entry command queue sets when busy rises.
// Reset: synchronous, active low; store comes up empty, no clearing pass.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          in_cmd,
  input  logic signed [31:0]  in_operand,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic signed [31:0]  out_element,
  output logic                out_last_of_run
);
  import ddq_pkg::*;

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;
  q_item_t push_item;
  q_item_t q_item;

  // decode and classify
  ddq_front u_front (
    .start      (start),
    .q_full     (q_full),
    .in_cmd     (in_cmd),
    .in_operand (in_operand),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  // command queue
  ddq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // execution and storage
  ddq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_element     (out_element),
    .out_last_of_run (out_last_of_run)
  );

endmodule
